### design/qpm_pkg.sv
// ----------------------------------------------------------------------------
// qpm_pkg
// Constants and the arctangent table shared by the quadratic phase multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
package qpm_pkg;
	localparam int COORD_BITS = 12;
	localparam int PHASE_BITS = 48;
	localparam int Z_BITS = 32;
	localparam int ITERS = 24;
	localparam int FRAC_BITS = 24;
	localparam int KINV_BITS = 25;
	localparam logic signed [KINV_BITS-1:0] KINV_Q24 = 25'sd10188014;

	localparam logic [1:0] REG_HALF_ROWS = 2'd0;
	localparam logic [1:0] REG_HALF_COLS = 2'd1;
	localparam logic [1:0] REG_ROW_STEP = 2'd2;
	localparam logic [1:0] REG_COL_STEP = 2'd3;

	function automatic logic signed [Z_BITS-1:0] atan_turn(input int i);
		logic signed [Z_BITS-1:0] v;
		case (i)
			0: v = 32'sd536870912;
			1: v = 32'sd316933406;
			2: v = 32'sd167458907;
			3: v = 32'sd85004756;
			4: v = 32'sd42667331;
			5: v = 32'sd21354465;
			6: v = 32'sd10679838;
			7: v = 32'sd5340245;
			8: v = 32'sd2670163;
			9: v = 32'sd1335087;
			10: v = 32'sd667544;
			11: v = 32'sd333772;
			12: v = 32'sd166886;
			13: v = 32'sd83443;
			14: v = 32'sd41722;
			15: v = 32'sd20861;
			16: v = 32'sd10430;
			17: v = 32'sd5215;
			18: v = 32'sd2608;
			19: v = 32'sd1304;
			20: v = 32'sd652;
			21: v = 32'sd326;
			22: v = 32'sd163;
			23: v = 32'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

### design/qpm_front.sv
// ----------------------------------------------------------------------------
// qpm_front
// Configuration registers, phase computation, gain scaling and quadrant turn.
// ----------------------------------------------------------------------------
`default_nettype none
module qpm_front #(
	parameter int MAX_SIDE = 4096,
	parameter int SAMPLE_BITS = 16,
	parameter int W = SAMPLE_BITS + 26
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [qpm_pkg::PHASE_BITS-1:0] cfg_data,
	input wire logic in_valid,
	input wire logic signed [SAMPLE_BITS-1:0] pixel_re,
	input wire logic signed [SAMPLE_BITS-1:0] pixel_im,
	input wire logic [qpm_pkg::COORD_BITS-1:0] row,
	input wire logic [qpm_pkg::COORD_BITS-1:0] col,
	input wire logic full,
	output logic push,
	output logic [2*W+qpm_pkg::Z_BITS-1:0] push_data
);
	localparam int CB = qpm_pkg::COORD_BITS;
	localparam int PB = qpm_pkg::PHASE_BITS;
	localparam int LIM = (MAX_SIDE < (1 << CB)) ? MAX_SIDE - 1 : (1 << CB) - 1;
	localparam int PW = SAMPLE_BITS + qpm_pkg::KINV_BITS;

	logic [CB-1:0] half_rows_q, half_cols_q;
	logic [PB-1:0] row_step_q, col_step_q;
	logic fe;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [CB:0] n_s1, m_s1;
	logic signed [SAMPLE_BITS-1:0] re_s1, im_s1, re_s2, im_s2;
	logic [2*CB-1:0] nn_s2, mm_s2;
	logic [PB-1:0] rlo_s3, clo_s3;
	logic [PB/2-1:0] rhi_s3, chi_s3;
	logic signed [PW-1:0] x_s3, y_s3, x_s4, y_s4;
	logic [PB-1:0] p_s4;
	logic [CB-1:0] row_c, col_c;
	logic signed [2*CB+1:0] nsq, msq;
	logic [PB-1:0] rhi_full, chi_full, pa;
	logic signed [PB-1:0] r, rz;
	logic signed [W-1:0] xe, ye, xr, yr;

	assign fe = !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_rows_q <= CB'(256);
			half_cols_q <= CB'(256);
			row_step_q <= '0;
			col_step_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				qpm_pkg::REG_HALF_ROWS: half_rows_q <= cfg_data[CB-1:0];
				qpm_pkg::REG_HALF_COLS: half_cols_q <= cfg_data[CB-1:0];
				qpm_pkg::REG_ROW_STEP: row_step_q <= cfg_data;
				qpm_pkg::REG_COL_STEP: col_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (fe) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		row_c = (int'(row) > LIM) ? CB'(LIM) : row;
		col_c = (int'(col) > LIM) ? CB'(LIM) : col;
		nsq = n_s1 * n_s1;
		msq = m_s1 * m_s1;
		rhi_full = PB'(row_step_q[PB-1:PB/2] * nn_s2);
		chi_full = PB'(col_step_q[PB-1:PB/2] * mm_s2);
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			n_s1 <= $signed({1'b0, row_c}) - $signed({1'b0, half_rows_q});
			m_s1 <= $signed({1'b0, col_c}) - $signed({1'b0, half_cols_q});
			re_s1 <= pixel_re;
			im_s1 <= pixel_im;
			nn_s2 <= nsq[2*CB-1:0];
			mm_s2 <= msq[2*CB-1:0];
			re_s2 <= re_s1;
			im_s2 <= im_s1;
			rlo_s3 <= PB'(row_step_q[PB/2-1:0] * nn_s2);
			clo_s3 <= PB'(col_step_q[PB/2-1:0] * mm_s2);
			rhi_s3 <= rhi_full[PB/2-1:0];
			chi_s3 <= chi_full[PB/2-1:0];
			x_s3 <= re_s2 * qpm_pkg::KINV_Q24;
			y_s3 <= im_s2 * qpm_pkg::KINV_Q24;
			p_s4 <= rlo_s3 + clo_s3 + {rhi_s3, {(PB/2){1'b0}}} + {chi_s3, {(PB/2){1'b0}}};
			x_s4 <= x_s3;
			y_s4 <= y_s3;
		end
	end

	always_comb begin
		pa = p_s4 + (PB'(1) << (PB - 3));
		r = $signed({2'b00, pa[PB-3:0]}) - $signed(PB'(1) << (PB - 3));
		rz = r + $signed(PB'(1) << 15);
		xe = W'(x_s4);
		ye = W'(y_s4);
		case (pa[PB-1:PB-2])
			2'd1: begin
				xr = -ye;
				yr = xe;
			end
			2'd2: begin
				xr = -xe;
				yr = -ye;
			end
			2'd3: begin
				xr = ye;
				yr = -xe;
			end
			default: begin
				xr = xe;
				yr = ye;
			end
		endcase
		push = v_s4 && fe;
		push_data = {xr, yr, rz[PB-1:16]};
	end
endmodule
`default_nettype wire

### design/qpm_fifo.sv
// ----------------------------------------------------------------------------
// qpm_fifo
// Short word queue between the phase front end and the rotation back end.
// ----------------------------------------------------------------------------
`default_nettype none
module qpm_fifo #(
	parameter int WIDTH = 116,
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] push_data,
	input wire logic pop,
	output logic [WIDTH-1:0] pop_data,
	output logic full,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

### design/qpm_back.sv
// ----------------------------------------------------------------------------
// qpm_back
// Pipelined CORDIC rotation, rounding and saturation with output register.
// ----------------------------------------------------------------------------
`default_nettype none
module qpm_back #(
	parameter int SAMPLE_BITS = 16,
	parameter int W = SAMPLE_BITS + 26
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [2*W+qpm_pkg::Z_BITS-1:0] pop_data,
	input wire logic empty,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_re,
	output logic signed [SAMPLE_BITS-1:0] out_im
);
	localparam int N = qpm_pkg::ITERS;
	localparam int ZB = qpm_pkg::Z_BITS;
	localparam int FB = qpm_pkg::FRAC_BITS;
	localparam int RB = W + 1 - FB;

	logic be;
	logic v_q [N+1];
	logic signed [W-1:0] x_q [N+1];
	logic signed [W-1:0] y_q [N+1];
	logic signed [ZB-1:0] z_q [N+1];

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [W-1:0] v);
		logic signed [W:0] t;
		logic signed [RB-1:0] s;
		logic signed [RB-1:0] hi, lo;
		hi = RB'((1 << (SAMPLE_BITS - 1)) - 1);
		lo = -hi - $signed(RB'(1));
		t = $signed({v[W-1], v}) + $signed((W+1)'(1) << (FB - 1));
		s = t[W:FB];
		if (s > hi)
			return hi[SAMPLE_BITS-1:0];
		if (s < lo)
			return lo[SAMPLE_BITS-1:0];
		return s[SAMPLE_BITS-1:0];
	endfunction

	assign be = !out_valid || out_ready;
	assign pop = be && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++)
				v_q[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (be) begin
			v_q[0] <= !empty;
			for (int k = 0; k < N; k++)
				v_q[k+1] <= v_q[k];
			out_valid <= v_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			x_q[0] <= pop_data[2*W+ZB-1:W+ZB];
			y_q[0] <= pop_data[W+ZB-1:ZB];
			z_q[0] <= pop_data[ZB-1:0];
			for (int k = 0; k < N; k++) begin
				if (!z_q[k][ZB-1]) begin
					x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] - qpm_pkg::atan_turn(k);
				end else begin
					x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] + qpm_pkg::atan_turn(k);
				end
			end
			out_re <= sat(x_q[N]);
			out_im <= sat(y_q[N]);
		end
	end
endmodule
`default_nettype wire

### design/quadratic_phase_multiply.sv
// ----------------------------------------------------------------------------
// quadratic_phase_multiply
// Multiplies a complex pixel by a quadratic phase set by its centred position.
// ----------------------------------------------------------------------------
// Pipeline: 4 front stages, one queue slot, 25 CORDIC stages and the output
// register. Throughput: one pixel per cycle when neither side stalls, set by
// the fully pipelined CORDIC.
// Reset: asynchronous, clears valids and queue, centres to 256, steps to 0.
`default_nettype none
module quadratic_phase_multiply #(
	parameter int MAX_SIDE = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [qpm_pkg::PHASE_BITS-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [SAMPLE_BITS-1:0] pixel_re,
	input wire logic signed [SAMPLE_BITS-1:0] pixel_im,
	input wire logic [qpm_pkg::COORD_BITS-1:0] row,
	input wire logic [qpm_pkg::COORD_BITS-1:0] col,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_re,
	output logic signed [SAMPLE_BITS-1:0] out_im
);
	localparam int W = SAMPLE_BITS + 26;
	localparam int FW = 2 * W + qpm_pkg::Z_BITS;

	logic push, pop, full, empty;
	logic [FW-1:0] push_data, pop_data;

	assign in_ready = !full;

	qpm_front #(.MAX_SIDE(MAX_SIDE), .SAMPLE_BITS(SAMPLE_BITS), .W(W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .pixel_re(pixel_re), .pixel_im(pixel_im),
		.row(row), .col(col),
		.full(full), .push(push), .push_data(push_data)
	);

	qpm_fifo #(.WIDTH(FW), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data),
		.pop(pop), .pop_data(pop_data),
		.full(full), .empty(empty)
	);

	qpm_back #(.SAMPLE_BITS(SAMPLE_BITS), .W(W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_data(pop_data), .empty(empty), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_re(out_re), .out_im(out_im)
	);
endmodule
`default_nettype wire

### bench/tb_quadratic_phase_multiply.sv
// ----------------------------------------------------------------------------
// tb_quadratic_phase_multiply
// Streams complex pixels with positions through the quadratic phase multiplier
// under several centre and step settings, with random stalls on both sides,
// and checks every rotated pixel against a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_quadratic_phase_multiply;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam longint unsigned PMASK = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		logic has_typed;
		logic signed [SB-1:0] re;
		logic signed [SB-1:0] im;
	} pixel_tag_t;

	typedef struct {
		logic signed [SB-1:0] re;
		logic signed [SB-1:0] im;
	} rot_pixel_t;

	typedef struct {
		int cfg_set;
		logic signed [SB-1:0] re;
		logic signed [SB-1:0] im;
		logic [11:0] r;
		logic [11:0] c;
		logic has_typed;
		logic signed [SB-1:0] exp_re;
		logic signed [SB-1:0] exp_im;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [qpm_pkg::PHASE_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [SB-1:0] pixel_re;
	logic signed [SB-1:0] pixel_im;
	logic [qpm_pkg::COORD_BITS-1:0] row;
	logic [qpm_pkg::COORD_BITS-1:0] col;
	logic out_valid;
	logic out_ready;
	logic signed [SB-1:0] out_re;
	logic signed [SB-1:0] out_im;

	quadratic_phase_multiply dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_re(pixel_re), .pixel_im(pixel_im), .row(row), .col(col),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_re(out_re), .out_im(out_im)
	);

	always #1 clk = ~clk;

	logic [11:0] cur_half_rows = 12'd256;
	logic [11:0] cur_half_cols = 12'd256;
	logic [47:0] cur_row_step = 48'd0;
	logic [47:0] cur_col_step = 48'd0;

	pixel_tag_t tag_q[$];
	rot_pixel_t rotated_q[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_req = 0;
	int quiet_cycles = 0;

	longint atan_tab[24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	function automatic logic signed [SB-1:0] round_sat(longint v);
		longint t;
		t = (v + (64'sd1 <<< 23)) >>> 24;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t[SB-1:0];
	endfunction

	function automatic rot_pixel_t rotate_pixel(logic signed [SB-1:0] re,
			logic signed [SB-1:0] im, logic [11:0] r, logic [11:0] c);
		longint n, m, sr, z, x0, y0, x, y, dx, dy;
		longint unsigned nn, mm, p, q, ru;
		rot_pixel_t res;
		n = longint'({52'd0, r}) - longint'({52'd0, cur_half_rows});
		m = longint'({52'd0, c}) - longint'({52'd0, cur_half_cols});
		nn = n * n;
		mm = m * m;
		p = ({16'd0, cur_row_step} * nn + {16'd0, cur_col_step} * mm) & PMASK;
		q = ((p + (64'd1 << 45)) >> 46) & 64'd3;
		ru = (p - (q << 46)) & PMASK;
		sr = ru[47] ? longint'(ru) - (64'sd1 <<< 48) : longint'(ru);
		z = (sr + 64'sd32768) >>> 16;
		x0 = longint'(re) * 10188014;
		y0 = longint'(im) * 10188014;
		case (q)
			1: begin x = -y0; y = x0; end
			2: begin x = -x0; y = -y0; end
			3: begin x = y0; y = -x0; end
			default: begin x = x0; y = y0; end
		endcase
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_tab[i];
			end else begin
				x = x + dx; y = y - dy; z = z + atan_tab[i];
			end
		end
		res.re = round_sat(x);
		res.im = round_sat(y);
		return res;
	endfunction

	always @(posedge clk) begin
		pixel_tag_t t;
		rot_pixel_t e;
		if (arst_n && in_valid && in_ready) begin
			e = rotate_pixel(pixel_re, pixel_im, row, col);
			if (tag_q.size() > 0) begin
				t = tag_q.pop_front();
				if (t.has_typed) begin
					e.re = t.re;
					e.im = t.im;
				end
			end
			rotated_q.push_back(e);
		end
	end

	always @(posedge clk) begin
		rot_pixel_t e;
		if (arst_n && out_valid && out_ready) begin
			if (rotated_q.size() == 0) begin
				$error("unexpected word out_re=%0d out_im=%0d", out_re, out_im);
				errors++;
			end else begin
				e = rotated_q.pop_front();
				if (out_re !== e.re) begin
					$error("out_re expected %0d actual %0d", e.re, out_re);
					errors++;
				end
				if (out_im !== e.im) begin
					$error("out_im expected %0d actual %0d", e.im, out_im);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= arst_n && ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send_pixel(logic signed [SB-1:0] re, logic signed [SB-1:0] im,
			logic [11:0] r, logic [11:0] c, logic has_typed,
			logic signed [SB-1:0] exp_re, logic signed [SB-1:0] exp_im);
		pixel_tag_t t;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		t.has_typed = has_typed;
		t.re = exp_re;
		t.im = exp_im;
		tag_q.push_back(t);
		in_valid <= 1'b1;
		pixel_re <= re;
		pixel_im <= im;
		row <= r;
		col <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rotated_q.size() > 0 || tag_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [11:0] hr, logic [11:0] hc,
			logic [47:0] rs, logic [47:0] cs);
		cfg_we <= 1'b1;
		cfg_index <= qpm_pkg::REG_HALF_ROWS;
		cfg_data <= {36'd0, hr};
		@(posedge clk);
		cfg_index <= qpm_pkg::REG_HALF_COLS;
		cfg_data <= {36'd0, hc};
		@(posedge clk);
		cfg_index <= qpm_pkg::REG_ROW_STEP;
		cfg_data <= rs;
		@(posedge clk);
		cfg_index <= qpm_pkg::REG_COL_STEP;
		cfg_data <= cs;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_half_rows = hr;
		cur_half_cols = hc;
		cur_row_step = rs;
		cur_col_step = cs;
		@(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom_range(65535)), $urandom()};
	endfunction

	function automatic logic [11:0] near_coord(logic [11:0] centre);
		if ($urandom_range(3) == 0)
			return 12'($urandom_range(4095));
		return centre + 12'($urandom_range(64)) - 12'd32;
	endfunction

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	directed_row_t directed[] = '{
		'{0, 16'sd0, 16'sd0, 12'd256, 12'd256, 1'b1, 16'sd0, 16'sd0},
		'{0, 16'sd0, 16'sd0, 12'd4095, 12'd0, 1'b1, 16'sd0, 16'sd0},
		'{0, 16'sh7FFF, 16'sh7FFF, 12'd0, 12'd0, 1'b0, 16'sd0, 16'sd0},
		'{0, 16'sh8000, 16'sh8000, 12'd4095, 12'd4095, 1'b0, 16'sd0, 16'sd0},
		'{0, 16'sh7FFF, 16'sh8000, 12'd256, 12'd256, 1'b0, 16'sd0, 16'sd0},
		'{0, 16'sh8000, 16'sh7FFF, 12'd0, 12'd4095, 1'b0, 16'sd0, 16'sd0},
		'{0, 16'sd1, -16'sd1, 12'd255, 12'd257, 1'b0, 16'sd0, 16'sd0},
		'{0, 16'sh5555, 16'shAAAA, 12'hAAA, 12'h555, 1'b0, 16'sd0, 16'sd0},
		'{1, 16'sd0, 16'sd0, 12'd4095, 12'd4095, 1'b1, 16'sd0, 16'sd0},
		'{1, 16'sh7FFF, 16'sh7FFF, 12'd1, 12'd0, 1'b0, 16'sd0, 16'sd0},
		'{1, 16'sh8000, 16'sh8000, 12'd1, 12'd0, 1'b0, 16'sd0, 16'sd0},
		'{1, 16'sh7FFF, 16'sd0, 12'd0, 12'd1, 1'b0, 16'sd0, 16'sd0},
		'{1, 16'sh8000, 16'sh8000, 12'd1, 12'd1, 1'b0, 16'sd0, 16'sd0},
		'{1, 16'sh7FFF, 16'sh8000, 12'd3, 12'd2, 1'b0, 16'sd0, 16'sd0},
		'{1, 16'sh1234, -16'sd4321, 12'd4095, 12'd4095, 1'b0, 16'sd0, 16'sd0},
		'{1, 16'sd0, 16'sh7FFF, 12'd0, 12'd0, 1'b0, 16'sd0, 16'sd0}
	};

	initial begin
		logic [11:0] p_hr[7];
		logic [11:0] p_hc[7];
		logic [47:0] p_rs[7];
		logic [47:0] p_cs[7];
		int cur_set;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= qpm_pkg::REG_HALF_ROWS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		pixel_re <= '0;
		pixel_im <= '0;
		row <= '0;
		col <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 23;
		recv_idle = 58;
		cur_set = 0;
		foreach (directed[i]) begin
			if (directed[i].cfg_set != cur_set) begin
				drain();
				set_config(12'd0, 12'd0, 48'h2000_0000_0000, 48'h4000_0000_0000);
				cur_set = directed[i].cfg_set;
			end
			send_pixel(directed[i].re, directed[i].im, directed[i].r, directed[i].c,
				directed[i].has_typed, directed[i].exp_re, directed[i].exp_im);
		end

		p_hr = '{12'd256, 12'd0, 12'd2048, 12'd4095, 12'($urandom_range(4095)), 12'd1000,
			12'($urandom_range(4095))};
		p_hc = '{12'd256, 12'd0, 12'd2048, 12'd4095, 12'($urandom_range(4095)), 12'd3000,
			12'($urandom_range(4095))};
		p_rs = '{rand48(), 48'hFFFF_FFFF_FFFF, rand48(), 48'd0, rand48(),
			48'h8000_0000_0000, rand48()};
		p_cs = '{rand48(), 48'd1, 48'd0, rand48(), rand48(),
			48'h8000_0000_0000, rand48()};

		for (int k = 0; k < 7; k++) begin
			drain();
			set_config(p_hr[k], p_hc[k], p_rs[k], p_cs[k]);
			if (k < 2) begin
				send_idle = 23; recv_idle = 58;
			end else if (k < 4) begin
				send_idle = 58; recv_idle = 23;
			end else begin
				send_idle = 0; recv_idle = 0;
			end
			if (k == 4) hold_req = hold_req + 1;
			for (int j = 0; j < 250; j++)
				send_pixel(rand_sample(), rand_sample(), near_coord(p_hr[k]),
					near_coord(p_hc[k]), 1'b0, 16'sd0, 16'sd0);
		end

		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
design/qpm_pkg.sv
design/qpm_front.sv
design/qpm_fifo.sv
design/qpm_back.sv
design/quadratic_phase_multiply.sv
bench/tb_quadratic_phase_multiply.sv
